[design/txcon_pkg.sv]
// ----------------------------------------------------------------------------
// txcon_pkg
// Shared types and constants of the text console: character and action codes,
// field widths, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
package txcon_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned CURSOR_W = 12;

  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LINEFEED,
    ST_SCROLL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   read_char;
    logic                scrolled;
  } res_t;

endpackage

[design/text_console_cursor_scroll_core.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Character-cell text console with cursor, line feed blanking and one-line
// scroll, with a registered result stage on the output side.
// ----------------------------------------------------------------------------
// Sequence: a put of a plain character, CR or backspace goes from acceptance
//   to the result hand-off step, a read through the store read step first;
//   a line feed blanks to the end of the line and a scroll sweeps all
//   TOTAL_CELLS cells, one store write per cycle. A new request is taken
//   only when idle, after the last result has gone to the output register.
// Reset: cursor to zero, then a clearing pass writes spaces to all TOTAL_CELLS
//   cells of the store while input is stalled.
module text_console_cursor_scroll_core import txcon_pkg::*; #(
  parameter int unsigned LINE_CELLS  = 128,
  parameter int unsigned TOTAL_CELLS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [INDEX_W-1:0]  read_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CURSOR_W-1:0] cursor_o,
  output logic [CHAR_W-1:0]   read_char_o,
  output logic                scrolled_o
);

  localparam int unsigned IDX_W = $clog2(TOTAL_CELLS);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  txcon_seq #(
    .LINE_CELLS  (LINE_CELLS),
    .TOTAL_CELLS (TOTAL_CELLS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .read_index_i (read_index_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  txcon_cell_mem #(
    .DEPTH (TOTAL_CELLS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cursor_o    = out_q.cursor;
  assign read_char_o = out_q.read_char;
  assign scrolled_o  = out_q.scrolled;

endmodule

[design/txcon_cell_mem.sv]
// ----------------------------------------------------------------------------
// txcon_cell_mem
// Character cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module txcon_cell_mem import txcon_pkg::*; #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [CHAR_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [CHAR_W-1:0]        rdata_o
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/txcon_seq.sv]
// ----------------------------------------------------------------------------
// txcon_seq
// Request sequencer: cursor and column registers, clearing pass, line feed
// blanking and the scroll copy sweep over the cell store.
// ----------------------------------------------------------------------------
module txcon_seq import txcon_pkg::*; #(
  parameter int unsigned LINE_CELLS  = 128,
  parameter int unsigned TOTAL_CELLS = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [CHAR_W-1:0]              char_code_i,
  input  logic [INDEX_W-1:0]             read_index_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output res_t                           res_o,
  output logic                           mem_we_o,
  output logic [$clog2(TOTAL_CELLS)-1:0] mem_waddr_o,
  output logic [CHAR_W-1:0]              mem_wdata_o,
  output logic [$clog2(TOTAL_CELLS)-1:0] mem_raddr_o,
  input  logic [CHAR_W-1:0]              mem_rdata_i
);

  localparam int unsigned IDX_W     = $clog2(TOTAL_CELLS);
  localparam int unsigned COL_W     = $clog2(LINE_CELLS);
  localparam int unsigned SCROLL_AT = TOTAL_CELLS - LINE_CELLS;
  localparam int unsigned HOME      = TOTAL_CELLS - 2 * LINE_CELLS;
  localparam int unsigned HOME_COL  = HOME % LINE_CELLS;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    cursor_q, cursor_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic                oor_q, oor_d;
  logic [CHAR_W-1:0]   rchar_q, rchar_d;
  logic                scrolled_q, scrolled_d;
  logic                rd_in_range;
  logic                col_last;

  assign rd_in_range = ({20'd0, read_index_i} < 32'(TOTAL_CELLS));
  assign col_last    = (col_q == COL_W'(LINE_CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cursor_q <= '0;
      col_q    <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oor_q      <= oor_d;
    rchar_q    <= rchar_d;
    scrolled_q <= scrolled_d;
  end

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    oor_d       = oor_q;
    rchar_d     = rchar_q;
    scrolled_d  = scrolled_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cursor_q;
    mem_wdata_o = CHAR_BLANK;
    mem_raddr_o = IDX_W'(read_index_i);
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        cnt_d       = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(TOTAL_CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          rchar_d    = '0;
          scrolled_d = 1'b0;
          if (action_i == ACT_READ) begin
            oor_d   = !rd_in_range;
            state_d = ST_READ;
          end else begin
            case (char_code_i)
              CHAR_BS, CHAR_DEL: begin
                if (col_q != '0) begin
                  cursor_d    = cursor_q - IDX_W'(1);
                  col_d       = col_q - COL_W'(1);
                  mem_we_o    = 1'b1;
                  mem_waddr_o = cursor_q - IDX_W'(1);
                end
              end
              CHAR_CR: begin
                cursor_d = cursor_q - IDX_W'(col_q);
                col_d    = '0;
              end
              CHAR_LF: begin
                state_d = ST_LINEFEED;
              end
              default: begin
                mem_we_o    = 1'b1;
                mem_wdata_o = char_code_i;
                cursor_d    = cursor_q + IDX_W'(1);
                col_d       = col_last ? '0 : col_q + COL_W'(1);
              end
            endcase
            if (char_code_i != CHAR_LF) begin
              if (cursor_d >= IDX_W'(SCROLL_AT)) begin
                // prime the read of the first source cell
                scrolled_d  = 1'b1;
                cnt_d       = '0;
                mem_raddr_o = IDX_W'(LINE_CELLS);
                state_d     = ST_SCROLL;
              end else begin
                state_d = ST_EMIT;
              end
            end
          end
        end
      end

      ST_READ: begin
        rchar_d = oor_q ? '0 : mem_rdata_i;
        state_d = ST_EMIT;
      end

      ST_LINEFEED: begin
        // blank one cell a cycle up to the end of the line
        mem_we_o = 1'b1;
        cursor_d = cursor_q + IDX_W'(1);
        col_d    = col_q + COL_W'(1);
        if (col_last) begin
          col_d = '0;
          if (cursor_d >= IDX_W'(SCROLL_AT)) begin
            scrolled_d  = 1'b1;
            cnt_d       = '0;
            mem_raddr_o = IDX_W'(LINE_CELLS);
            state_d     = ST_SCROLL;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end

      ST_SCROLL: begin
        // copy cell cnt+LINE down to cnt, read one ahead; blank the last line
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        mem_wdata_o = (cnt_q < IDX_W'(SCROLL_AT)) ? mem_rdata_i : CHAR_BLANK;
        mem_raddr_o = IDX_W'({1'b0, cnt_q} + (IDX_W + 1)'(LINE_CELLS + 1));
        cnt_d       = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(TOTAL_CELLS - 1)) begin
          cnt_d    = '0;
          cursor_d = IDX_W'(HOME);
          col_d    = COL_W'(HOME_COL);
          state_d  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.cursor    = CURSOR_W'(cursor_q);
  assign res_o.read_char = rchar_q;
  assign res_o.scrolled  = scrolled_q;

  a_cursor_above_last_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cursor_q < IDX_W'(SCROLL_AT)))
    else $error("cursor rests on the last line");

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < COL_W'(LINE_CELLS - 1) || col_q == COL_W'(LINE_CELLS - 1))
    else $error("column outside the line");

  a_scroll_lands_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && cnt_q == IDX_W'(TOTAL_CELLS - 1))
    |=> (state_q == ST_EMIT && cursor_q == IDX_W'(HOME) && scrolled_q))
    else $error("scroll did not finish at the home line");

  a_no_write_while_reporting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_EMIT) |-> !mem_we_o)
    else $error("store written while a result is pending");

endmodule
